// ----- rtl/xoodoo_pkg.sv -----
// Shared types and constants for the Xoodoo permutation unit.
// Self-contained; imported by xoodoo_stage and xoodoo_permutation_unit.
`default_nettype none

package xoodoo_pkg;

   localparam int unsigned LANE_WIDTH = 32;
   localparam int unsigned LANE_COUNT = 12;
   localparam int unsigned ROUND_TOTAL = 12;

   typedef logic [LANE_WIDTH-1:0] lane_type;
   typedef lane_type [LANE_COUNT-1:0] state_type;

   // Wide enough for a round index 0..11 and for the value twelve.
   typedef logic [3:0] round_idx_type;

   // Control that travels alongside the state from one stage to the next.
   typedef struct packed {
      logic          valid;
      round_idx_type first_round;
   } stage_ctl_type;

   localparam round_idx_type ROUND_LIMIT = round_idx_type'(ROUND_TOTAL);

   // Published round constants, first round first.
   localparam lane_type RC_TABLE [ROUND_TOTAL] = '{
      32'h0000_0058, 32'h0000_0038, 32'h0000_03C0, 32'h0000_00D0,
      32'h0000_0120, 32'h0000_0014, 32'h0000_0060, 32'h0000_002C,
      32'h0000_0380, 32'h0000_00F0, 32'h0000_01A0, 32'h0000_0012
   };

endpackage : xoodoo_pkg

`default_nettype wire

// ----- rtl/xoodoo_stage.sv -----
// One Xoodoo pipeline stage: a single round or a pass-through, and its register.
// Depends on xoodoo_pkg.
`default_nettype none

module xoodoo_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  xoodoo_pkg::round_idx_type round_index,
   input  xoodoo_pkg::stage_ctl_type up_ctl,
   input  xoodoo_pkg::state_type     up_state,
   output logic                      up_ready,
   input  logic                      dn_ready,
   output xoodoo_pkg::stage_ctl_type dn_ctl,
   output xoodoo_pkg::state_type     dn_state
);
   import xoodoo_pkg::*;

   logic          valid_ff;
   logic          valid_in;
   round_idx_type first_ff;
   state_type     state_ff;
   state_type     state_in;

   lane_type      par [4];
   lane_type      eff [4];
   state_type     mixed;
   state_type     west;
   state_type     chied;
   state_type     rounded;
   logic          apply_round;

   always_comb begin
      for (int x = 0; x < 4; x++) begin
         par[x] = up_state[x] ^ up_state[x + 4] ^ up_state[x + 8];
      end
      for (int x = 0; x < 4; x++) begin
         eff[x] = {par[(x + 3) % 4][26:0], par[(x + 3) % 4][31:27]}
                ^ {par[(x + 3) % 4][17:0], par[(x + 3) % 4][31:18]};
      end
      for (int x = 0; x < 4; x++) begin
         for (int y = 0; y < 3; y++) begin
            mixed[4 * y + x] = up_state[4 * y + x] ^ eff[x];
         end
      end
      for (int x = 0; x < 4; x++) begin
         west[x]     = mixed[x];
         west[4 + x] = mixed[4 + ((x + 3) % 4)];
         west[8 + x] = {mixed[8 + x][20:0], mixed[8 + x][31:21]};
      end
      west[0] = west[0] ^ RC_TABLE[round_index];
      for (int x = 0; x < 4; x++) begin
         chied[x]     = west[x]     ^ (~west[4 + x] & west[8 + x]);
         chied[4 + x] = west[4 + x] ^ (~west[8 + x] & west[x]);
         chied[8 + x] = west[8 + x] ^ (~west[x]     & west[4 + x]);
      end
      for (int x = 0; x < 4; x++) begin
         rounded[x]     = chied[x];
         rounded[4 + x] = {chied[4 + x][30:0], chied[4 + x][31]};
         rounded[8 + x] = {chied[8 + ((x + 2) % 4)][23:0],
                           chied[8 + ((x + 2) % 4)][31:24]};
      end
   end

   // Rounds before the transaction's first round pass the state through.
   assign apply_round = (round_index >= up_ctl.first_round);
   assign state_in    = apply_round ? rounded : up_state;
   assign up_ready    = !valid_ff || dn_ready;
   assign valid_in    = up_ready ? up_ctl.valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_ctl.valid) begin
         state_ff <= state_in;
         first_ff <= up_ctl.first_round;
      end
   end

   assign dn_ctl   = '{valid: valid_ff, first_round: first_ff};
   assign dn_state = state_ff;

endmodule : xoodoo_stage

`default_nettype wire

// ----- rtl/xoodoo_permutation_unit.sv -----
// Top level of the Xoodoo permutation unit: twelve round stages in a pipeline.
// Depends on xoodoo_pkg and xoodoo_stage.
//
//   Channel   Direction  Handshake                    Carries
//   req_      in         req_valid / req_ready        twelve 32-bit state lanes
//   rsp_      out        rsp_valid / rsp_ready        twelve permuted lanes
//   csr_      in         csr_write_enable, no wait    round_count (4 bits)
//
// Every transaction passes through twelve register stages, one Xoodoo round per
// stage, whatever the round count, and a new transaction can be taken in every
// cycle unless a stall on rsp_ has backed up to the input. The round count is
// sampled on acceptance; stages ahead of its first round forward it unchanged.
// Synchronous reset empties the pipeline and sets the round count to twelve.
// A stall on rsp_ travels back only as far as the stages that hold work, so
// empty stages keep filling; nothing is dropped or repeated.
`default_nettype none

module xoodoo_permutation_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [3:0]           csr_write_data,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  xoodoo_pkg::lane_type req_lane_0,
   input  xoodoo_pkg::lane_type req_lane_1,
   input  xoodoo_pkg::lane_type req_lane_2,
   input  xoodoo_pkg::lane_type req_lane_3,
   input  xoodoo_pkg::lane_type req_lane_4,
   input  xoodoo_pkg::lane_type req_lane_5,
   input  xoodoo_pkg::lane_type req_lane_6,
   input  xoodoo_pkg::lane_type req_lane_7,
   input  xoodoo_pkg::lane_type req_lane_8,
   input  xoodoo_pkg::lane_type req_lane_9,
   input  xoodoo_pkg::lane_type req_lane_10,
   input  xoodoo_pkg::lane_type req_lane_11,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output xoodoo_pkg::lane_type rsp_out_lane_0,
   output xoodoo_pkg::lane_type rsp_out_lane_1,
   output xoodoo_pkg::lane_type rsp_out_lane_2,
   output xoodoo_pkg::lane_type rsp_out_lane_3,
   output xoodoo_pkg::lane_type rsp_out_lane_4,
   output xoodoo_pkg::lane_type rsp_out_lane_5,
   output xoodoo_pkg::lane_type rsp_out_lane_6,
   output xoodoo_pkg::lane_type rsp_out_lane_7,
   output xoodoo_pkg::lane_type rsp_out_lane_8,
   output xoodoo_pkg::lane_type rsp_out_lane_9,
   output xoodoo_pkg::lane_type rsp_out_lane_10,
   output xoodoo_pkg::lane_type rsp_out_lane_11
);
   import xoodoo_pkg::*;

   round_idx_type round_count_ff;
   round_idx_type round_count_in;
   round_idx_type rounds_sat;
   round_idx_type first_round;

   stage_ctl_type ctl_chain   [ROUND_TOTAL + 1];
   state_type     state_chain [ROUND_TOTAL + 1];
   logic          ready_chain [ROUND_TOTAL + 1];
   state_type     last_state;

   // The configuration register is written without handshake.
   assign round_count_in = csr_write_enable ? csr_write_data : round_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         round_count_ff <= ROUND_LIMIT;
      end else begin
         round_count_ff <= round_count_in;
      end
   end

   // Counts above twelve saturate; the first applied round is twelve minus
   // the count, so a count of zero lets the state through untouched.
   assign rounds_sat  = (round_count_ff > ROUND_LIMIT) ? ROUND_LIMIT : round_count_ff;
   assign first_round = ROUND_LIMIT - rounds_sat;

   assign ctl_chain[0] = '{valid: req_valid, first_round: first_round};

   assign state_chain[0][0]  = req_lane_0;
   assign state_chain[0][1]  = req_lane_1;
   assign state_chain[0][2]  = req_lane_2;
   assign state_chain[0][3]  = req_lane_3;
   assign state_chain[0][4]  = req_lane_4;
   assign state_chain[0][5]  = req_lane_5;
   assign state_chain[0][6]  = req_lane_6;
   assign state_chain[0][7]  = req_lane_7;
   assign state_chain[0][8]  = req_lane_8;
   assign state_chain[0][9]  = req_lane_9;
   assign state_chain[0][10] = req_lane_10;
   assign state_chain[0][11] = req_lane_11;

   assign req_ready = ready_chain[0];
   assign ready_chain[ROUND_TOTAL] = rsp_ready;

   for (genvar k = 0; k < ROUND_TOTAL; k++) begin : g_round
      xoodoo_stage u_stage (
         .clock       (clock),
         .reset       (reset),
         .round_index (round_idx_type'(k)),
         .up_ctl      (ctl_chain[k]),
         .up_state    (state_chain[k]),
         .up_ready    (ready_chain[k]),
         .dn_ready    (ready_chain[k + 1]),
         .dn_ctl      (ctl_chain[k + 1]),
         .dn_state    (state_chain[k + 1])
      );
   end

   // The last stage register doubles as the result register.
   assign rsp_valid  = ctl_chain[ROUND_TOTAL].valid;
   assign last_state = state_chain[ROUND_TOTAL];

   assign rsp_out_lane_0  = last_state[0];
   assign rsp_out_lane_1  = last_state[1];
   assign rsp_out_lane_2  = last_state[2];
   assign rsp_out_lane_3  = last_state[3];
   assign rsp_out_lane_4  = last_state[4];
   assign rsp_out_lane_5  = last_state[5];
   assign rsp_out_lane_6  = last_state[6];
   assign rsp_out_lane_7  = last_state[7];
   assign rsp_out_lane_8  = last_state[8];
   assign rsp_out_lane_9  = last_state[9];
   assign rsp_out_lane_10 = last_state[10];
   assign rsp_out_lane_11 = last_state[11];

   // When the result stage is empty or being drained, the whole pipe moves.
   a_drain_opens_input : assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("input blocked although the result stage can move");

   // A stage holding a transaction behind a blocked successor keeps it.
   a_mid_stage_holds : assert property (@(posedge clock) disable iff (reset)
      (ctl_chain[6].valid && !ready_chain[6]) |=> ctl_chain[6].valid)
      else $error("a stalled transaction was lost in mid pipeline");

   // The first applied round never lies beyond twelve, the value that applies no round.
   a_first_round_range : assert property (@(posedge clock) disable iff (reset)
      req_valid |-> (first_round <= ROUND_LIMIT))
      else $error("first round out of range");

   // A configuration write takes effect in the next cycle.
   a_csr_write : assert property (@(posedge clock) disable iff (reset)
      csr_write_enable |=> (round_count_ff == $past(csr_write_data)))
      else $error("round count not updated by write");

endmodule : xoodoo_permutation_unit

`default_nettype wire
